[hw/rtl/scrl_pkg.sv]
// Package: shared constants, types and helpers for the send cooldown rate limiter.
`timescale 1ns / 1ps
`default_nettype none
package scrl_pkg;
   localparam int unsigned SENDERS_DEF    = 64;
   localparam int unsigned SCOPES_DEF     = 16;
   localparam int unsigned SRING_DEF      = 16;
   localparam int unsigned GRING_DEF      = 64;
   localparam int unsigned WINDOW_MS_DEF  = 60000;
   localparam int unsigned TIME_W         = 40;
   localparam int unsigned CSR_W          = 12;
   localparam int unsigned CSR_IDX_W      = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_SENDER_COOL = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCOPE_COOL  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SCOPE_LIM   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GLOBAL_LIM  = 2'd3;

   typedef enum logic [2:0] {
      RSN_NONE        = 3'd0,
      RSN_SENDER_COOL = 3'd1,
      RSN_SCOPE_COOL  = 3'd2,
      RSN_SCOPE_RATE  = 3'd3,
      RSN_GLOBAL_RATE = 3'd4
   } reason_type;

   // Ring entry check: a stored time is expired when zero or older than the window.
   function automatic logic is_expired(input logic [TIME_W-1:0] t,
                                       input logic [TIME_W-1:0] now,
                                       input logic [TIME_W-1:0] win);
      logic [TIME_W-1:0] d;
      d = now - t;
      is_expired = (t == '0) || ((now >= t) && (d > win));
   endfunction
endpackage
`default_nettype wire

[hw/rtl/send_cooldown_rate_limiter.sv]
// Top level: cooldown and sliding window send limiter sequencer.
// Sequence: read, cooldown check, scope and global ring trims (one dropped entry at a time), done;
//   a cooldown block goes straight to done, and a scope limit block skips the global trim.
// Throughput: one transaction at a time; busy falls as rsp_valid rises.
// Reset: synchronous, active high; clears the configuration, ring heads and counts and valid
//   bits of the last-send tables. Ring contents are not cleared. Results cannot be stalled.
`timescale 1ns / 1ps
`default_nettype none
module send_cooldown_rate_limiter #(
   parameter int unsigned SENDERS           = scrl_pkg::SENDERS_DEF,
   parameter int unsigned SCOPES            = scrl_pkg::SCOPES_DEF,
   parameter int unsigned SCOPE_RING_DEPTH  = scrl_pkg::SRING_DEF,
   parameter int unsigned GLOBAL_RING_DEPTH = scrl_pkg::GRING_DEF,
   parameter int unsigned WINDOW_MS         = scrl_pkg::WINDOW_MS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic                          req_command,
   input  wire logic [5:0]                    req_sender_index,
   input  wire logic [3:0]                    req_scope_index,
   input  wire logic                          req_direct_address,
   input  wire logic [scrl_pkg::TIME_W-1:0]   req_now_ms,
   output logic                               rsp_valid,
   output logic                               rsp_allowed,
   output logic [2:0]                         rsp_block_reason,
   input  wire logic                          csr_we,
   input  wire logic [scrl_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [scrl_pkg::CSR_W-1:0]    csr_wdata
);
   import scrl_pkg::*;

   localparam int unsigned SND_W  = (SENDERS > 1) ? $clog2(SENDERS) : 1;
   localparam int unsigned SCP_W  = (SCOPES > 1) ? $clog2(SCOPES) : 1;
   localparam int unsigned SR_W   = (SCOPE_RING_DEPTH > 1) ? $clog2(SCOPE_RING_DEPTH) : 1;
   localparam int unsigned SRC_W  = $clog2(SCOPE_RING_DEPTH + 1);
   localparam int unsigned GR_W   = (GLOBAL_RING_DEPTH > 1) ? $clog2(GLOBAL_RING_DEPTH) : 1;
   localparam int unsigned GRC_W  = $clog2(GLOBAL_RING_DEPTH + 1);
   localparam int unsigned SMEM_D = SCOPES * SCOPE_RING_DEPTH;
   localparam int unsigned SMA_W  = (SMEM_D > 1) ? $clog2(SMEM_D) : 1;
   localparam int unsigned SLIM_C = SCOPE_RING_DEPTH;
   localparam int unsigned GLIM_C = GLOBAL_RING_DEPTH;
   localparam logic [TIME_W-1:0] WIN = TIME_W'(WINDOW_MS);

   typedef enum logic [2:0] {
      ST_IDLE, ST_READ, ST_COOL, ST_STRIM, ST_GTRIM, ST_DONE
   } state_type;

   // Configuration registers
   logic [11:0] snd_cool_ff, scp_cool_ff;
   logic [4:0]  scp_lim_ff;
   logic [6:0]  glb_lim_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         snd_cool_ff <= '0;
         scp_cool_ff <= '0;
         scp_lim_ff  <= '0;
         glb_lim_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SENDER_COOL: snd_cool_ff <= csr_wdata;
            CSR_SCOPE_COOL:  scp_cool_ff <= csr_wdata;
            CSR_SCOPE_LIM:   scp_lim_ff  <= csr_wdata[4:0];
            CSR_GLOBAL_LIM:  glb_lim_ff  <= csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   // Last-send tables: memories with valid bits standing for the zero reset
   logic [TIME_W-1:0] snd_last_mem [SENDERS];
   logic [TIME_W-1:0] scp_last_mem [SCOPES];
   logic [SENDERS-1:0] snd_vld_ff;
   logic [SCOPES-1:0]  scp_vld_ff;
   logic [TIME_W-1:0]  snd_last_rd, scp_last_rd;
   logic               snd_vld_rd, scp_vld_rd;
   // Per-scope ring head and count, global head and count
   logic [SR_W-1:0]  s_head_ff [SCOPES];
   logic [SRC_W-1:0] s_cnt_ff  [SCOPES];
   logic [GR_W-1:0]  g_head_ff;
   logic [GRC_W-1:0] g_cnt_ff;

   // Request registers
   state_type         state_ff;
   logic              cmd_ff, dir_ff;
   logic [SND_W-1:0]  snd_ff;
   logic [SCP_W-1:0]  scp_ff;
   logic [TIME_W-1:0] now_ff;
   logic [2:0]        rsn_ff;
   logic [SR_W-1:0]   sh_ff;
   logic [SRC_W-1:0]  sc_ff;
   logic [GR_W-1:0]   gh_ff;
   logic [GRC_W-1:0]  gc_ff;
   logic              rd_pend_ff;
   logic              rsp_valid_ff, rsp_allowed_ff;
   logic [2:0]        rsp_rsn_ff;

   logic [SND_W-1:0] snd_idx;
   logic [SCP_W-1:0] scp_idx;
   assign snd_idx = SND_W'(32'(req_sender_index) % SENDERS);
   assign scp_idx = SCP_W'(32'(req_scope_index) % SCOPES);

   // Ring memories
   logic              s_we, g_we;
   logic [SMA_W-1:0]  s_waddr, s_raddr;
   logic [GR_W-1:0]   g_waddr, g_raddr;
   logic [TIME_W-1:0] s_rd, g_rd;

   scrl_ring_mem #(.DEPTH(SMEM_D), .WIDTH(TIME_W)) u_sring (
      .clock(clock), .wr_en(s_we), .wr_addr(s_waddr), .wr_data(now_ff),
      .rd_addr(s_raddr), .rd_data(s_rd));
   scrl_ring_mem #(.DEPTH(GLOBAL_RING_DEPTH), .WIDTH(TIME_W)) u_gring (
      .clock(clock), .wr_en(g_we), .wr_addr(g_waddr), .wr_data(now_ff),
      .rd_addr(g_raddr), .rd_data(g_rd));

   logic [SMA_W-1:0] s_base;
   assign s_base  = SMA_W'(32'(scp_ff) * SCOPE_RING_DEPTH);
   assign s_raddr = s_base + SMA_W'(sh_ff);
   assign g_raddr = gh_ff;

   // Cooldown comparisons
   logic [TIME_W-1:0] snd_el, scp_el, snd_cms, scp_cms;
   logic snd_block, scp_block;
   assign snd_el  = now_ff - snd_last_rd;
   assign scp_el  = now_ff - scp_last_rd;
   assign snd_cms = TIME_W'(22'(snd_cool_ff) * 22'd1000);
   assign scp_cms = TIME_W'(22'(scp_cool_ff) * 22'd1000);
   assign snd_block = (snd_cool_ff != '0) && snd_vld_rd && (snd_last_rd != '0) &&
                      ((now_ff < snd_last_rd) || (snd_el < snd_cms));
   assign scp_block = (scp_cool_ff != '0) && scp_vld_rd && (scp_last_rd != '0) &&
                      ((now_ff < scp_last_rd) || (scp_el < scp_cms));

   // Saturated limits
   logic [SRC_W-1:0] s_lim;
   logic [GRC_W-1:0] g_lim;
   assign s_lim = (32'(scp_lim_ff) > SLIM_C) ? SRC_W'(SLIM_C) : SRC_W'(scp_lim_ff);
   assign g_lim = (32'(glb_lim_ff) > GLIM_C) ? GRC_W'(GLIM_C) : GRC_W'(glb_lim_ff);

   logic s_exp, g_exp, commit;
   assign s_exp = is_expired(s_rd, now_ff, WIN);
   assign g_exp = is_expired(g_rd, now_ff, WIN);
   assign commit = (state_ff == ST_DONE) && cmd_ff && (rsn_ff == RSN_NONE);

   // Ring write on commit: tail slot wraps by one compare and subtract
   logic [SR_W-1:0] s_wslot;
   logic [GR_W-1:0] g_wslot;
   logic [SR_W:0]   s_sum;
   logic [GR_W:0]   g_sum;
   assign s_sum = {1'b0, sh_ff} + (SR_W+1)'(sc_ff);
   assign g_sum = {1'b0, gh_ff} + (GR_W+1)'(gc_ff);
   always_comb begin
      if (32'(sc_ff) < SCOPE_RING_DEPTH) begin
         if (s_sum >= (SR_W+1)'(SCOPE_RING_DEPTH)) begin
            s_wslot = SR_W'(s_sum - (SR_W+1)'(SCOPE_RING_DEPTH));
         end else begin
            s_wslot = SR_W'(s_sum);
         end
      end else begin
         s_wslot = sh_ff;
      end
      if (32'(gc_ff) < GLOBAL_RING_DEPTH) begin
         if (g_sum >= (GR_W+1)'(GLOBAL_RING_DEPTH)) begin
            g_wslot = GR_W'(g_sum - (GR_W+1)'(GLOBAL_RING_DEPTH));
         end else begin
            g_wslot = GR_W'(g_sum);
         end
      end else begin
         g_wslot = gh_ff;
      end
   end
   assign s_we    = commit;
   assign g_we    = commit;
   assign s_waddr = s_base + SMA_W'(s_wslot);
   assign g_waddr = g_wslot;

   // Last-send memories: write on commit, read on accept
   always_ff @(posedge clock) begin
      if (commit) begin
         snd_last_mem[snd_ff] <= now_ff;
         scp_last_mem[scp_ff] <= now_ff;
      end
      if (start && !busy) begin
         snd_last_rd <= snd_last_mem[snd_idx];
         scp_last_rd <= scp_last_mem[scp_idx];
         snd_vld_rd  <= snd_vld_ff[snd_idx];
         scp_vld_rd  <= scp_vld_ff[scp_idx];
      end
   end

   function automatic logic [SR_W-1:0] s_inc(input logic [SR_W-1:0] h);
      s_inc = (h == SR_W'(SCOPE_RING_DEPTH - 1)) ? '0 : h + 1'b1;
   endfunction
   function automatic logic [GR_W-1:0] g_inc(input logic [GR_W-1:0] h);
      g_inc = (h == GR_W'(GLOBAL_RING_DEPTH - 1)) ? '0 : h + 1'b1;
   endfunction

   // Sequencer: read state, cool check, trim scope ring, trim global ring, commit
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         snd_vld_ff   <= '0;
         scp_vld_ff   <= '0;
         g_head_ff    <= '0;
         g_cnt_ff     <= '0;
         rd_pend_ff   <= 1'b0;
         for (int i = 0; i < SCOPES; i++) begin
            s_head_ff[i] <= '0;
            s_cnt_ff[i]  <= '0;
         end
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  cmd_ff   <= req_command;
                  dir_ff   <= req_direct_address;
                  snd_ff   <= snd_idx;
                  scp_ff   <= scp_idx;
                  now_ff   <= req_now_ms;
                  rsn_ff   <= RSN_NONE;
                  state_ff <= ST_READ;
               end
            end
            ST_READ: begin
               sh_ff    <= s_head_ff[scp_ff];
               sc_ff    <= s_cnt_ff[scp_ff];
               gh_ff    <= g_head_ff;
               gc_ff    <= g_cnt_ff;
               state_ff <= ST_COOL;
            end
            ST_COOL: begin
               rd_pend_ff <= 1'b1;
               if (!dir_ff && snd_block) begin
                  rsn_ff   <= RSN_SENDER_COOL;
                  state_ff <= ST_DONE;
               end else if (!dir_ff && scp_block) begin
                  rsn_ff   <= RSN_SCOPE_COOL;
                  state_ff <= ST_DONE;
               end else begin
                  state_ff <= ST_STRIM;
               end
            end
            ST_STRIM: begin
               // one ring entry at a time; rd_pend marks a fresh read of the head
               if (rd_pend_ff) begin
                  rd_pend_ff <= 1'b0;
               end else if (sc_ff != '0 && s_exp) begin
                  sh_ff      <= s_inc(sh_ff);
                  sc_ff      <= sc_ff - 1'b1;
                  rd_pend_ff <= 1'b1;
               end else begin
                  rd_pend_ff <= 1'b1;
                  if (!dir_ff && scp_lim_ff != '0 && sc_ff >= s_lim) begin
                     rsn_ff   <= RSN_SCOPE_RATE;
                     state_ff <= ST_DONE;
                  end else begin
                     state_ff <= ST_GTRIM;
                  end
               end
            end
            ST_GTRIM: begin
               if (rd_pend_ff) begin
                  rd_pend_ff <= 1'b0;
               end else if (gc_ff != '0 && g_exp) begin
                  gh_ff      <= g_inc(gh_ff);
                  gc_ff      <= gc_ff - 1'b1;
                  rd_pend_ff <= 1'b1;
               end else begin
                  if (glb_lim_ff != '0 && gc_ff >= g_lim) begin
                     rsn_ff <= RSN_GLOBAL_RATE;
                  end
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               // write back heads and counts, record on an allowed consume
               s_head_ff[scp_ff] <= sh_ff;
               s_cnt_ff[scp_ff]  <= sc_ff;
               g_head_ff         <= gh_ff;
               g_cnt_ff          <= gc_ff;
               if (commit) begin
                  snd_vld_ff[snd_ff] <= 1'b1;
                  scp_vld_ff[scp_ff] <= 1'b1;
                  if (32'(sc_ff) < SCOPE_RING_DEPTH) begin
                     s_cnt_ff[scp_ff] <= sc_ff + 1'b1;
                  end else begin
                     s_head_ff[scp_ff] <= s_inc(sh_ff);
                  end
                  if (32'(gc_ff) < GLOBAL_RING_DEPTH) begin
                     g_cnt_ff <= gc_ff + 1'b1;
                  end else begin
                     g_head_ff <= g_inc(gh_ff);
                  end
               end
               rsp_valid_ff   <= 1'b1;
               rsp_allowed_ff <= (rsn_ff == RSN_NONE);
               rsp_rsn_ff     <= rsn_ff;
               rd_pend_ff     <= 1'b0;
               state_ff       <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_allowed      = rsp_allowed_ff;
   assign rsp_block_reason = rsp_rsn_ff;
endmodule
`default_nettype wire

[hw/rtl/scrl_ring_mem.sv]
// Simple synchronous memory with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module scrl_ring_mem #(
   parameter int unsigned DEPTH = 16,
   parameter int unsigned WIDTH = 40
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   // Write and read the array; read data is registered and lands in the cycle after its address.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

[hw/rtl/scrl_checker.sv]
// Checker: port-level properties of the send limiter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module scrl_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       start,
   input wire logic       busy,
   input wire logic       rsp_valid,
   input wire logic       rsp_allowed,
   input wire logic [2:0] rsp_block_reason
);
   import scrl_pkg::*;

   // Allowed results carry no reason, blocked ones do.
   a_allow_reason: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_allowed == (rsp_block_reason == RSN_NONE)))
      else $error("reason mismatch");
   // Reasons stay in the defined range.
   a_reason_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_block_reason <= RSN_GLOBAL_RATE)) else $error("reason out of range");
   // An accepted transaction makes the block busy next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("busy missing");
   // A result strobe comes as busy falls.
   a_rsp_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!busy && $past(busy))) else $error("stray result");
endmodule

bind send_cooldown_rate_limiter scrl_checker u_scrl_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy), .rsp_valid(rsp_valid),
   .rsp_allowed(rsp_allowed), .rsp_block_reason(rsp_block_reason));
`default_nettype wire
